[rtl/core/bcle_pkg.sv]
// Shared types, constants and the CRC32 byte step for the command link engine.
`timescale 1ns / 1ps
`default_nettype none
package bcle_pkg;

  localparam logic [31:0] CrcPoly = 32'h04C11DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam int unsigned QDepth = 4;
  localparam int unsigned PlanDepth = 6;

  // function codes
  localparam logic [2:0] FnInfo   = 3'd1;
  localparam logic [2:0] FnUpdate = 3'd2;
  localparam logic [2:0] FnSize   = 3'd5;
  localparam logic [2:0] FnBase   = 3'd6;
  localparam logic [2:0] FnErase  = 3'd7;

  // response frame types (second word of a response)
  localparam logic [31:0] RspAck   = 32'd1;
  localparam logic [31:0] RspInfo  = 32'd2;
  localparam logic [31:0] RspErase = 32'd4;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_RX      = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_SUCCESS = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_PERIOD  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CRC,
    ST_APPLY,
    ST_JUDGE,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  function_code;
    logic [31:0] argument;
    logic [8:0]  payload_count;
    logic [31:0] word;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    action_e  op;
    logic     has_arg;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] crc;
    logic [31:0] word;
  } crc_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] crc;
  } crc_rsp_t;

  // Eight MSB-first steps of the CRC32 shift register.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[31] ^ data[7-i];
      c  = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/bootloader_command_link_engine.sv]
// Top level of the bootloader command link engine (host side).
//
// Input channel (in_valid_i / in_stall_o / in_item_i): start, payload word,
// received response word or millisecond tick. A front register takes one
// transaction per cycle into a four-entry command queue; in_stall_o rises only
// while the queue is full and the front register is occupied.
// Output channel (out_valid_o / out_stall_i / out_item_o): transmit words,
// reported words, success or timeout, with last set on the final result of
// each input transaction. A stalled result holds in the output register while
// the front keeps accepting.
// The back end handles one command at a time. Each CRC word goes through the
// byte-wide CRC unit in turn; a start sends two or three words there, a
// payload word and a response word one each (none for the word that ends a
// frame), and a tick may run the 16-step remainder of the resend check.
// From acceptance, a transaction passes the front register, the queue and
// the back end before its first result reaches the output register.
// Reset empties the queue, goes idle, restores timeout 100 and resend period
// 20 ticks. Configuration writes take effect at once and have no read-back.
`timescale 1ns / 1ps
`default_nettype none
module bootloader_command_link_engine #(
  parameter int unsigned MAX_PAYLOAD_WORDS = 256,
  parameter int unsigned RESP_WORDS        = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bcle_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bcle_pkg::out_item_t  out_item_o
);
  import bcle_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  cmd_t     push_cmd;
  cmd_t     head_cmd;
  crc_req_t crc_req;
  crc_rsp_t crc_rsp;

  bcle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (q_push),
    .cmd_o      (push_cmd),
    .full_i     (q_full)
  );

  bcle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  bcle_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .rsp_o  (crc_rsp)
  );

  bcle_back #(
    .MAX_PAYLOAD_WORDS (MAX_PAYLOAD_WORDS),
    .RESP_WORDS        (RESP_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .crc_req_o   (crc_req),
    .crc_rsp_i   (crc_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("command queue underflow");

  a_crc_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_req.start |=> !crc_req.start) else $error("CRC unit restarted while busy");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_SUCCESS || out_item_o.kind == KIND_FAIL)
    |-> out_item_o.value == 32'd0 && out_item_o.last)
    else $error("completion result carries data or is not last");
`endif

endmodule
`default_nettype wire

[rtl/core/bcle_front.sv]
// Front end: input register that classifies transactions and feeds the command queue.
`timescale 1ns / 1ps
`default_nettype none
module bcle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bcle_pkg::in_item_t  in_item_i,
  output logic                push_o,
  output bcle_pkg::cmd_t      cmd_o,
  input  logic                full_i
);
  import bcle_pkg::*;

  logic  f_valid_q, f_valid_d;
  cmd_t  f_cmd_q, f_cmd_d;
  logic  accept;
  logic  keep;

  assign in_stall_o = f_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && !full_i;
  assign cmd_o      = f_cmd_q;

  // a start with no function code does nothing: drop it here
  assign keep = !((action_e'(in_item_i.action) == ACT_START) &&
                  (in_item_i.function_code == 3'd0));

  always_comb begin
    f_valid_d = f_valid_q;
    f_cmd_d   = f_cmd_q;
    if (push_o) begin
      f_valid_d = 1'b0;
    end
    if (accept) begin
      f_valid_d       = keep;
      f_cmd_d.op      = action_e'(in_item_i.action);
      f_cmd_d.has_arg = (in_item_i.function_code == FnSize) ||
                        (in_item_i.function_code == FnBase);
      f_cmd_d.item    = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_cmd_q <= f_cmd_d;
  end

endmodule
`default_nettype wire

[rtl/core/bcle_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module bcle_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bcle_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bcle_pkg::cmd_t  head_o
);
  import bcle_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bcle_crc.sv]
// CRC32 unit: one 32-bit word per request, a byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bcle_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcle_pkg::crc_req_t  req_i,
  output bcle_pkg::crc_rsp_t  rsp_o
);
  import bcle_pkg::*;

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] c_q, c_d;
  logic [31:0] w_q, w_d;

  assign rsp_o.done = done_q;
  assign rsp_o.crc  = c_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    c_d    = c_q;
    w_d    = w_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      c_d   = req_i.crc;
      w_d   = req_i.word;
    end else if (run_q) begin
      c_d   = crc_byte(c_q, w_q[31:24]);
      w_d   = {w_q[23:0], 8'd0};
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    w_q <= w_d;
  end

endmodule
`default_nettype wire

[rtl/core/bcle_back.sv]
// Back end: command sequencer, response checker, wait timer and result register.
`timescale 1ns / 1ps
`default_nettype none
module bcle_back #(
  parameter int unsigned MAX_PAYLOAD_WORDS = 256,
  parameter int unsigned RESP_WORDS        = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 q_empty_i,
  input  bcle_pkg::cmd_t       q_head_i,
  output logic                 q_pop_o,
  output bcle_pkg::crc_req_t   crc_req_o,
  input  bcle_pkg::crc_rsp_t   crc_rsp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bcle_pkg::out_item_t  out_item_o
);
  import bcle_pkg::*;

  localparam int unsigned CntW    = $clog2(MAX_PAYLOAD_WORDS + 1);
  localparam int unsigned IdxW    = $clog2(RESP_WORDS + 1);
  localparam int unsigned WordsSz = (RESP_WORDS > 8) ? RESP_WORDS : 8;
  localparam int unsigned WAddrW  = $clog2(WordsSz);

  back_state_e state_q, state_d;

  // command state
  logic            busy_q, busy_d;
  logic [2:0]      code_q, code_d;
  logic [31:0]     arg_q, arg_d;
  logic [31:0]     req_crc_q, req_crc_d;
  logic [31:0]     tx_crc_q, tx_crc_d;
  logic [CntW-1:0] left_q, left_d;
  logic [15:0]     wait_q, wait_d;
  logic [15:0]     timeout_q, timeout_d;
  logic [7:0]      period_q, period_d;

  // receive state
  logic [IdxW-1:0]       rx_idx_q, rx_idx_d;
  logic [31:0]           rx_crc_q, rx_crc_d;
  logic [RESP_WORDS-1:0] rx_match_q, rx_match_d;
  logic [31:0]           rx_words_q [WordsSz];
  logic                  rx_we;
  logic [WordsSz-1:0]    match_ext;

  // work registers
  cmd_t        cur_q, cur_d;
  logic [31:0] crc_w_q [3];
  logic [31:0] crc_w_d [3];
  logic [1:0]  crc_n_q, crc_n_d;
  logic [1:0]  crc_k_q, crc_k_d;
  logic [31:0] crc_acc_q, crc_acc_d;
  logic        crc_go_q, crc_go_d;
  logic        crc_last;
  logic [7:0]  rem_q, rem_d;
  logic [3:0]  div_k_q, div_k_d;
  logic [8:0]  div_t;
  logic [7:0]  rem_next;

  // result plan and output register
  kind_e       plan_kind_q [PlanDepth];
  kind_e       plan_kind_d [PlanDepth];
  logic [31:0] plan_val_q [PlanDepth];
  logic [31:0] plan_val_d [PlanDepth];
  logic [2:0]  plan_n_q, plan_n_d;
  logic [2:0]  emit_k_q, emit_k_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        slot_free;
  logic        emit_last;

  // decoded conditions
  logic            start_upd;
  logic            start_arg;
  logic [CntW-1:0] start_cnt;
  logic [31:0]     start_len;
  logic            pay_ok;
  logic            rx_room;
  logic            tick_ok;
  logic [15:0]     wait_inc;
  logic            tick_fail;
  logic            tick_resend;
  logic            plain_arg;
  logic            judge_hit;
  logic            hit_info;
  logic            hit_erase;
  logic            hit_ack;

  assign start_upd = (cur_q.item.function_code == FnUpdate);
  assign start_arg = start_upd || cur_q.has_arg;
  assign start_cnt = (32'(cur_q.item.payload_count) > 32'(MAX_PAYLOAD_WORDS)) ?
                     CntW'(MAX_PAYLOAD_WORDS) : CntW'(cur_q.item.payload_count);
  assign start_len = start_upd ? 32'(start_cnt) + 32'd4 :
                     (cur_q.has_arg ? 32'd4 : 32'd3);

  assign pay_ok      = busy_q && (left_q != '0);
  assign rx_room     = (32'(rx_idx_q) < 32'(RESP_WORDS));
  assign tick_ok     = busy_q && (left_q == '0);
  assign wait_inc    = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;
  assign tick_fail   = (wait_inc >= timeout_q);
  assign tick_resend = (code_q != FnUpdate) && (period_q != 8'd0);
  assign plain_arg   = (code_q == FnSize) || (code_q == FnBase);

  assign crc_last = crc_rsp_i.done && (crc_k_q == crc_n_q - 2'd1);

  // restoring remainder of the wait count by the resend period, one bit a cycle
  assign div_t    = {rem_q, wait_q[4'd15 - div_k_q]};
  assign rem_next = (div_t >= {1'b0, period_q}) ? 8'(div_t - {1'b0, period_q}) :
                    div_t[7:0];

  always_comb begin
    match_ext = '0;
    match_ext[RESP_WORDS-1:0] = rx_match_q;
  end

  assign hit_info  = (code_q == FnInfo) && (rx_words_q[1] == RspInfo) &&
                     (32'(rx_idx_q) > 32'd7) && match_ext[7];
  assign hit_erase = (code_q == FnErase) && (rx_words_q[1] == RspErase) &&
                     (32'(rx_idx_q) > 32'd3) && match_ext[3];
  assign hit_ack   = (code_q != FnInfo) && (code_q != FnErase) &&
                     (32'(rx_idx_q) >= 32'd6) && (rx_words_q[1] == RspAck) &&
                     (rx_words_q[2] == 32'(code_q)) && (rx_words_q[3] == req_crc_q) &&
                     ((code_q != FnUpdate) || (rx_words_q[4] == arg_q)) &&
                     match_ext[5];
  assign judge_hit = busy_q && (left_q == '0) && (32'(rx_idx_q) >= 32'd2) &&
                     (hit_info || hit_erase || hit_ack);

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_last = (emit_k_q == plan_n_q - 3'd1);

  assign crc_req_o.start = (state_q == ST_CRC) && crc_go_q;
  assign crc_req_o.crc   = crc_acc_q;
  assign crc_req_o.word  = crc_w_q[crc_k_q];

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        unique case (cur_q.op)
          ACT_START:   state_d = ST_CRC;
          ACT_PAYLOAD: state_d = pay_ok ? ST_CRC : ST_IDLE;
          ACT_RX: begin
            if (cur_q.item.frame_end) begin
              state_d = ST_JUDGE;
            end else begin
              state_d = rx_room ? ST_CRC : ST_IDLE;
            end
          end
          ACT_TICK: begin
            if (!tick_ok) begin
              state_d = ST_IDLE;
            end else if (tick_fail) begin
              state_d = ST_EMIT;
            end else begin
              state_d = tick_resend ? ST_DIV : ST_IDLE;
            end
          end
        endcase
      end
      ST_CRC: begin
        if (crc_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = (cur_q.op == ACT_RX) ? ST_IDLE : ST_EMIT;
      ST_JUDGE: state_d = judge_hit ? ST_EMIT : ST_IDLE;
      ST_DIV: begin
        if (div_k_q == 4'd15) begin
          state_d = (rem_next == 8'd0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [2:0] pn;
    pn          = '0;
    busy_d      = busy_q;
    code_d      = code_q;
    arg_d       = arg_q;
    req_crc_d   = req_crc_q;
    tx_crc_d    = tx_crc_q;
    left_d      = left_q;
    wait_d      = wait_q;
    timeout_d   = timeout_q;
    period_d    = period_q;
    rx_idx_d    = rx_idx_q;
    rx_crc_d    = rx_crc_q;
    rx_match_d  = rx_match_q;
    rx_we       = 1'b0;
    cur_d       = cur_q;
    crc_w_d     = crc_w_q;
    crc_n_d     = crc_n_q;
    crc_k_d     = crc_k_q;
    crc_acc_d   = crc_acc_q;
    crc_go_d    = crc_go_q;
    rem_d       = rem_q;
    div_k_d     = div_k_q;
    plan_kind_d = plan_kind_q;
    plan_val_d  = plan_val_q;
    plan_n_d    = plan_n_q;
    emit_k_d    = emit_k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TIMEOUT: timeout_d = cfg_data_i;
        CFG_PERIOD:  period_d  = cfg_data_i[7:0];
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          cur_d = q_head_i;
        end
      end
      ST_PREP: begin
        unique case (cur_q.op)
          ACT_START: begin
            crc_w_d[0] = start_len;
            crc_w_d[1] = 32'(cur_q.item.function_code);
            crc_w_d[2] = cur_q.item.argument;
            crc_n_d    = start_arg ? 2'd3 : 2'd2;
            crc_k_d    = '0;
            crc_acc_d  = CrcInit;
            crc_go_d   = 1'b1;
          end
          ACT_PAYLOAD: begin
            crc_w_d[0] = cur_q.item.word;
            crc_n_d    = 2'd1;
            crc_k_d    = '0;
            crc_acc_d  = tx_crc_q;
            crc_go_d   = pay_ok;
          end
          ACT_RX: begin
            if (rx_room) begin
              rx_we    = 1'b1;
              rx_idx_d = rx_idx_q + IdxW'(1);
              if (cur_q.item.word == rx_crc_q) begin
                rx_match_d = rx_match_q | (RESP_WORDS'(1) << rx_idx_q);
              end
            end
            crc_w_d[0] = cur_q.item.word;
            crc_n_d    = 2'd1;
            crc_k_d    = '0;
            crc_acc_d  = rx_crc_q;
            crc_go_d   = rx_room && !cur_q.item.frame_end;
          end
          ACT_TICK: begin
            rem_d   = '0;
            div_k_d = '0;
            if (tick_ok) begin
              wait_d = wait_inc;
              if (tick_fail) begin
                busy_d         = 1'b0;
                plan_kind_d[0] = KIND_FAIL;
                plan_val_d[0]  = '0;
                plan_n_d       = 3'd1;
                emit_k_d       = '0;
              end
            end
          end
        endcase
      end
      ST_CRC: begin
        crc_go_d = 1'b0;
        if (crc_rsp_i.done) begin
          crc_acc_d = crc_rsp_i.crc;
          crc_k_d   = crc_k_q + 2'd1;
          crc_go_d  = !crc_last;
        end
      end
      ST_APPLY: begin
        emit_k_d = '0;
        unique case (cur_q.op)
          ACT_START: begin
            busy_d   = 1'b1;
            code_d   = cur_q.item.function_code;
            wait_d   = '0;
            left_d   = start_upd ? start_cnt : '0;
            arg_d    = start_arg ? cur_q.item.argument : '0;
            tx_crc_d = crc_acc_q;
            plan_kind_d[pn] = KIND_TX;
            plan_val_d[pn]  = start_len;
            pn = pn + 3'd1;
            plan_kind_d[pn] = KIND_TX;
            plan_val_d[pn]  = 32'(cur_q.item.function_code);
            pn = pn + 3'd1;
            if (start_arg) begin
              plan_kind_d[pn] = KIND_TX;
              plan_val_d[pn]  = cur_q.item.argument;
              pn = pn + 3'd1;
            end
            if (!start_upd || (start_cnt == '0)) begin
              req_crc_d       = crc_acc_q;
              plan_kind_d[pn] = KIND_TX;
              plan_val_d[pn]  = crc_acc_q;
              pn = pn + 3'd1;
            end
            plan_n_d = pn;
          end
          ACT_PAYLOAD: begin
            tx_crc_d = crc_acc_q;
            left_d   = left_q - CntW'(1);
            plan_kind_d[0] = KIND_TX;
            plan_val_d[0]  = cur_q.item.word;
            plan_n_d       = 3'd1;
            if (left_q == CntW'(1)) begin
              req_crc_d      = crc_acc_q;
              plan_kind_d[1] = KIND_TX;
              plan_val_d[1]  = crc_acc_q;
              plan_n_d       = 3'd2;
            end
          end
          ACT_RX: rx_crc_d = crc_acc_q;
          ACT_TICK: ;
        endcase
      end
      ST_JUDGE: begin
        // frame boundary: start the next frame from scratch
        rx_idx_d   = '0;
        rx_crc_d   = CrcInit;
        rx_match_d = '0;
        emit_k_d   = '0;
        if (judge_hit) begin
          busy_d = 1'b0;
          if (hit_info) begin
            for (int i = 0; i < 5; i++) begin
              plan_kind_d[i] = KIND_REPORT;
              plan_val_d[i]  = rx_words_q[i+2];
            end
            plan_kind_d[5] = KIND_SUCCESS;
            plan_val_d[5]  = '0;
            plan_n_d       = 3'd6;
          end else if (hit_erase) begin
            plan_kind_d[0] = KIND_REPORT;
            plan_val_d[0]  = rx_words_q[2];
            plan_kind_d[1] = KIND_SUCCESS;
            plan_val_d[1]  = '0;
            plan_n_d       = 3'd2;
          end else begin
            plan_kind_d[0] = KIND_SUCCESS;
            plan_val_d[0]  = '0;
            plan_n_d       = 3'd1;
          end
        end
      end
      ST_DIV: begin
        rem_d    = rem_next;
        div_k_d  = div_k_q + 4'd1;
        emit_k_d = '0;
        // resend the stored request on a whole period
        if ((div_k_q == 4'd15) && (rem_next == 8'd0)) begin
          plan_kind_d[pn] = KIND_TX;
          plan_val_d[pn]  = plain_arg ? 32'd4 : 32'd3;
          pn = pn + 3'd1;
          plan_kind_d[pn] = KIND_TX;
          plan_val_d[pn]  = 32'(code_q);
          pn = pn + 3'd1;
          if (plain_arg) begin
            plan_kind_d[pn] = KIND_TX;
            plan_val_d[pn]  = arg_q;
            pn = pn + 3'd1;
          end
          plan_kind_d[pn] = KIND_TX;
          plan_val_d[pn]  = req_crc_q;
          pn = pn + 3'd1;
          plan_n_d = pn;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = plan_kind_q[emit_k_q];
          out_d.value = plan_val_q[emit_k_q];
          out_d.last  = emit_last;
          emit_k_d    = emit_k_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      code_q      <= '0;
      arg_q       <= '0;
      req_crc_q   <= '0;
      tx_crc_q    <= CrcInit;
      left_q      <= '0;
      wait_q      <= '0;
      timeout_q   <= 16'd100;
      period_q    <= 8'd20;
      rx_idx_q    <= '0;
      rx_crc_q    <= CrcInit;
      rx_match_q  <= '0;
      crc_go_q    <= 1'b0;
      crc_n_q     <= '0;
      crc_k_q     <= '0;
      div_k_q     <= '0;
      plan_n_q    <= '0;
      emit_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      code_q      <= code_d;
      arg_q       <= arg_d;
      req_crc_q   <= req_crc_d;
      tx_crc_q    <= tx_crc_d;
      left_q      <= left_d;
      wait_q      <= wait_d;
      timeout_q   <= timeout_d;
      period_q    <= period_d;
      rx_idx_q    <= rx_idx_d;
      rx_crc_q    <= rx_crc_d;
      rx_match_q  <= rx_match_d;
      crc_go_q    <= crc_go_d;
      crc_n_q     <= crc_n_d;
      crc_k_q     <= crc_k_d;
      div_k_q     <= div_k_d;
      plan_n_q    <= plan_n_d;
      emit_k_q    <= emit_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    crc_w_q     <= crc_w_d;
    crc_acc_q   <= crc_acc_d;
    rem_q       <= rem_d;
    plan_kind_q <= plan_kind_d;
    plan_val_q  <= plan_val_d;
    out_q       <= out_d;
    if (rx_we) begin
      rx_words_q[rx_idx_q[WAddrW-1:0]] <= cur_q.item.word;
    end
  end

endmodule
`default_nettype wire
